// ===== rtl/gsrp_pkg.sv =====
// Shared types and codes for the greedy shift-reduce parser
package gsrp_pkg;

  // Sizes fixed by the port widths
  localparam int STACK_DEPTH = 16;
  localparam int RULE_SLOTS  = 8;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SHIFT = 2'd1,
    REQ_END   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ACT_SHIFTED  = 3'd0,
    ACT_REDUCED  = 3'd1,
    ACT_ACCEPTED = 3'd2,
    ACT_REJECTED = 3'd3,
    ACT_OVERFLOW = 3'd4,
    ACT_LIMIT    = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       slot_clear;
    logic       slot_next;
    logic       sym_clear;
    logic       sym_next;
    logic       do_reduce;
    logic       do_shift;
    logic       do_overflow;
    logic       do_limit;
    logic       do_end;
    logic       red_clear;
  } cmd_t;

  typedef struct packed {
    logic slot_done;
    logic slot_ok;
    logic sym_done;
    logic sym_match;
    logic limit_reached;
    logic stack_full;
  } stat_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] rule_used;
    logic [7:0] pushed_symbol;
    logic [4:0] stack_level;
    logic       last;
  } result_t;

endpackage

// ===== rtl/gsrp_if.sv =====
// Valid/ready channel interfaces for requests, results and configuration
interface gsrp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  symbol;
  logic [2:0]  rule_slot;
  logic [7:0]  rule_left;
  logic [3:0]  rule_length;
  logic [63:0] rule_body_head;
  logic [7:0]  rule_body_tail;
  modport source (output valid, req_type, symbol, rule_slot, rule_left, rule_length,
                  rule_body_head, rule_body_tail, input ready);
  modport sink (input valid, req_type, symbol, rule_slot, rule_left, rule_length,
                rule_body_head, rule_body_tail, output ready);
endinterface

interface gsrp_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [2:0] rule_used;
  logic [7:0] pushed_symbol;
  logic [4:0] stack_level;
  logic       last;
  modport source (output valid, action, rule_used, pushed_symbol, stack_level, last,
                  input ready);
  modport sink (input valid, action, rule_used, pushed_symbol, stack_level, last,
                output ready);
endinterface

interface gsrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/greedy_shift_reduce_parser.sv =====
// Top level of the greedy shift-reduce parser
//
//   channel  dir  payload
//   req      in   req_type, symbol, rule fields
//   res      out  action, rule_used, pushed_symbol, stack_level, last
//   cfg      in   data (rules_in_use)
//
// A shift or end request runs a rule scan over the slots in order,
// comparing stack symbols for each usable rule, then emits each result;
// each reduction rescans from slot 0. A limit result is followed by the
// shift or end result, which is formed in the finish state after it.
// One request is in work at a time. Reset clears stack count, error and
// valid bits; a stalled result holds the block in its output state.
module greedy_shift_reduce_parser #(
  parameter int MAX_RIGHT_LENGTH = 9,
  parameter int MAX_REDUCTIONS   = 16
) (
  input logic clk,
  input logic rst,
  gsrp_req_if.sink   req,
  gsrp_res_if.source res,
  gsrp_cfg_if.sink   cfg
);
  import gsrp_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t result;
  logic    emit_last;
  logic    req_ready;

  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  gsrp_ctrl u_ctrl (
    .clk, .rst,
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .res_ready (res.ready),
    .res_valid (res.valid),
    .stat, .cmd, .emit_last
  );

  gsrp_dp #(
    .MAX_RIGHT_LENGTH(MAX_RIGHT_LENGTH), .MAX_REDUCTIONS(MAX_REDUCTIONS)
  ) u_dp (
    .clk, .rst,
    .load_en        (req.valid && req_ready && req.req_type == REQ_LOAD),
    .rule_slot      (req.rule_slot),
    .rule_left      (req.rule_left),
    .rule_length    (req.rule_length),
    .rule_body_head (req.rule_body_head),
    .rule_body_tail (req.rule_body_tail),
    .symbol         (req.symbol),
    .cfg_we         (cfg.valid),
    .cfg_data       (cfg.data),
    .cmd, .emit_last, .stat,
    .res            (result)
  );

  assign res.action        = result.action;
  assign res.rule_used     = result.rule_used;
  assign res.pushed_symbol = result.pushed_symbol;
  assign res.stack_level   = result.stack_level;
  assign res.last          = result.last;
endmodule

// ===== rtl/gsrp_ctrl.sv =====
// Controller state machine sequencing rule scans, reductions and results
module gsrp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [1:0]     req_type,
  output logic           req_ready,
  input  logic           res_ready,
  output logic           res_valid,
  input  gsrp_pkg::stat_t stat,
  output gsrp_pkg::cmd_t  cmd,
  output logic           emit_last
);
  import gsrp_pkg::*;

  state_t state, state_next;
  logic   is_end, is_end_next;
  logic   final_res, final_res_next;
  logic   to_finish, to_finish_next;

  // Hold the state and the kind of request being worked on
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      is_end    <= 1'b0;
      final_res <= 1'b0;
      to_finish <= 1'b0;
    end else begin
      state     <= state_next;
      is_end    <= is_end_next;
      final_res <= final_res_next;
      to_finish <= to_finish_next;
    end
  end

  logic go;
  assign go = req_valid && req_ready &&
              (req_t'(req_type) == REQ_SHIFT || req_t'(req_type) == REQ_END);

  // Next state
  always_comb begin
    state_next     = state;
    is_end_next    = is_end;
    final_res_next = final_res;
    to_finish_next = to_finish;
    unique case (state)
      ST_IDLE: if (go) begin
        state_next     = ST_SCAN;
        is_end_next    = (req_t'(req_type) == REQ_END);
        to_finish_next = 1'b0;
      end
      ST_SCAN:
        if (stat.slot_done) state_next = ST_FINISH;
        else if (stat.slot_ok) state_next = ST_CMP;
        else state_next = ST_SCAN;
      ST_CMP:
        if (!stat.sym_match) state_next = ST_SCAN;
        else if (stat.sym_done) begin
          state_next     = ST_EMIT;
          final_res_next = 1'b0;
          to_finish_next = stat.limit_reached;
        end
      ST_FINISH: begin
        state_next     = ST_EMIT;
        final_res_next = 1'b1;
        to_finish_next = 1'b0;
      end
      ST_EMIT:
        if (res_ready) begin
          if (final_res) state_next = ST_IDLE;
          else if (to_finish) state_next = ST_FINISH;
          else state_next = ST_SCAN;
        end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    res_valid = 1'b0;
    emit_last = final_res;
    unique case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.slot_clear = 1'b1;
        cmd.red_clear  = 1'b1;
      end
      ST_SCAN: begin
        cmd.sym_clear = 1'b1;
        if (!stat.slot_ok && !stat.slot_done) cmd.slot_next = 1'b1;
      end
      ST_CMP: begin
        if (!stat.sym_match) cmd.slot_next = 1'b1;
        else if (stat.sym_done) begin
          if (stat.limit_reached) cmd.do_limit = 1'b1;
          else cmd.do_reduce = 1'b1;
        end else cmd.sym_next = 1'b1;
      end
      ST_FINISH: begin
        if (is_end) cmd.do_end = 1'b1;
        else if (stat.stack_full) cmd.do_overflow = 1'b1;
        else cmd.do_shift = 1'b1;
      end
      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) cmd.slot_clear = 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/gsrp_dp.sv =====
// Datapath: rule store, symbol stack, matcher and result register
module gsrp_dp #(
  parameter int MAX_RIGHT_LENGTH = 9,
  parameter int MAX_REDUCTIONS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            load_en,
  input  logic [2:0]      rule_slot,
  input  logic [7:0]      rule_left,
  input  logic [3:0]      rule_length,
  input  logic [63:0]     rule_body_head,
  input  logic [7:0]      rule_body_tail,
  input  logic [7:0]      symbol,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_data,
  input  gsrp_pkg::cmd_t  cmd,
  input  logic            emit_last,
  output gsrp_pkg::stat_t stat,
  output gsrp_pkg::result_t res
);
  import gsrp_pkg::*;

  localparam int SW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int RW = $clog2(MAX_REDUCTIONS + 1);

  logic [7:0]  left_mem [RULE_SLOTS];
  logic [3:0]  len_mem  [RULE_SLOTS];
  logic [71:0] body_mem [RULE_SLOTS];
  logic [RULE_SLOTS-1:0] rule_valid;
  logic [7:0]  stack_mem [STACK_DEPTH];
  logic [CW-1:0] stack_count;
  logic        error_flag;
  logic [3:0]  rules_in_use;
  logic [SW:0] slot;
  logic [3:0]  sym_idx;
  logic [RW-1:0] red_cnt;
  logic [7:0]  sym_hold;

  logic [SW-1:0] s;
  logic [4:0]  lim;
  logic [3:0]  len;
  logic [CW-1:0] pos;
  logic [7:0]  body_sym;
  logic [CW-1:0] new_count;

  assign s   = slot[SW-1:0];
  assign lim = (rules_in_use > 4'(RULE_SLOTS)) ? 5'(RULE_SLOTS) : {1'b0, rules_in_use};
  assign len = len_mem[s];
  assign pos = stack_count - CW'(len) + CW'(sym_idx);
  assign body_sym = body_mem[s][{sym_idx, 3'b000} +: 8];
  assign new_count = stack_count - CW'(len) + CW'(1);

  // Status toward the controller
  always_comb begin
    stat.slot_done     = (5'(slot) >= lim);
    stat.slot_ok       = !stat.slot_done && rule_valid[s] && (CW'(len) <= stack_count);
    stat.sym_match     = (stack_mem[pos[AW-1:0]] == body_sym);
    stat.sym_done      = (sym_idx + 4'd1 >= len);
    stat.limit_reached = (red_cnt >= RW'(MAX_REDUCTIONS));
    stat.stack_full    = (stack_count >= CW'(STACK_DEPTH));
  end

  // Rule store and configuration register
  always_ff @(posedge clk) begin
    if (load_en && 32'(rule_slot) < RULE_SLOTS) begin
      left_mem[rule_slot[SW-1:0]] <= rule_left;
      len_mem[rule_slot[SW-1:0]]  <= rule_length;
      body_mem[rule_slot[SW-1:0]] <= {rule_body_tail, rule_body_head};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_valid   <= '0;
      rules_in_use <= 4'd8;
    end else begin
      if (load_en && 32'(rule_slot) < RULE_SLOTS)
        rule_valid[rule_slot[SW-1:0]] <= (rule_length >= 4'd1) &&
                                         (rule_length <= 4'(MAX_RIGHT_LENGTH));
      if (cfg_we) rules_in_use <= cfg_data;
    end
  end

  // Track the request symbol while idle, hold it once work starts
  always_ff @(posedge clk) begin
    if (cmd.red_clear) sym_hold <= symbol;
  end

  // Scan counters
  always_ff @(posedge clk) begin
    if (cmd.slot_clear) slot <= '0;
    else if (cmd.slot_next) slot <= slot + 1'b1;
    if (cmd.sym_clear) sym_idx <= '0;
    else if (cmd.sym_next) sym_idx <= sym_idx + 4'd1;
  end

  // Stack write
  always_ff @(posedge clk) begin
    if (cmd.do_reduce) stack_mem[new_count[AW-1:0] - AW'(1)] <= left_mem[s];
    else if (cmd.do_shift) stack_mem[stack_count[AW-1:0]] <= sym_hold;
  end

  // Stack count, error flag, reduction counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      error_flag  <= 1'b0;
      red_cnt     <= '0;
    end else begin
      if (cmd.red_clear) red_cnt <= '0;
      if (cmd.do_reduce) begin
        stack_count <= new_count;
        red_cnt     <= red_cnt + 1'b1;
      end
      if (cmd.do_shift) stack_count <= stack_count + 1'b1;
      if (cmd.do_overflow || cmd.do_limit) error_flag <= 1'b1;
      if (cmd.do_end) begin
        stack_count <= '0;
        error_flag  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_reduce) begin
      res.action        <= ACT_REDUCED;
      res.rule_used     <= 3'(s);
      res.pushed_symbol <= left_mem[s];
      res.stack_level   <= 5'(new_count);
    end else if (cmd.do_limit) begin
      res.action        <= ACT_LIMIT;
      res.rule_used     <= '0;
      res.pushed_symbol <= '0;
      res.stack_level   <= 5'(stack_count);
    end else if (cmd.do_shift) begin
      res.action        <= ACT_SHIFTED;
      res.rule_used     <= '0;
      res.pushed_symbol <= sym_hold;
      res.stack_level   <= 5'(stack_count + 1'b1);
    end else if (cmd.do_overflow) begin
      res.action        <= ACT_OVERFLOW;
      res.rule_used     <= '0;
      res.pushed_symbol <= sym_hold;
      res.stack_level   <= 5'(stack_count);
    end else if (cmd.do_end) begin
      res.action        <= (stack_count == CW'(1) && !error_flag) ? ACT_ACCEPTED
                                                                  : ACT_REJECTED;
      res.rule_used     <= '0;
      res.pushed_symbol <= '0;
      res.stack_level   <= 5'(stack_count);
    end
  end

  assign res.last = emit_last;
endmodule

// ===== rtl/gsrp_checker.sv =====
// Port-level checker for the parser, bound to the top level
module gsrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] action,
  input logic [4:0] stack_level,
  input logic       last
);
  import gsrp_pkg::*;

  // Never take a request while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready) else $error("request taken during result");

  // End results always close the request
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (action == ACT_ACCEPTED || action == ACT_REJECTED) |-> last)
    else $error("end result without last");

  // Accepted means exactly one symbol
  a_acc: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == ACT_ACCEPTED |-> stack_level == 5'd1)
    else $error("accept with wrong level");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(action))
    else $error("result dropped");
endmodule

bind greedy_shift_reduce_parser gsrp_checker u_gsrp_checker (
  .clk, .rst,
  .req_ready (req.ready),
  .res_valid (res.valid), .res_ready (res.ready),
  .action (res.action), .stack_level (res.stack_level), .last (res.last)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the greedy shift-reduce parser
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gsrp_pkg::*;

  localparam int DEPTH     = 16;
  localparam int SLOTS     = 8;
  localparam int MAX_LEN   = 9;
  localparam int MAX_RED   = 16;
  localparam int SETTLE    = 20;

  typedef struct {
    req_t        kind;
    logic [7:0]  symbol;
    logic [2:0]  slot;
    logic [7:0]  left;
    logic [3:0]  length;
    logic [63:0] head;
    logic [7:0]  tail;
  } request_t;

  typedef struct {
    request_t  rq;
    int        reps;
    bit        typed;
    act_t      t_act;
    int        t_level;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gsrp_req_if req_ch ();
  gsrp_res_if res_ch ();
  gsrp_cfg_if cfg_ch ();

  greedy_shift_reduce_parser uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #2 clk = ~clk;

  // Parser state mirrored for prediction
  logic [7:0]  stk [DEPTH];
  int          stk_cnt;
  logic [7:0]  r_left [SLOTS];
  logic [3:0]  r_len [SLOTS];
  logic [63:0] r_body [SLOTS];
  logic [7:0]  r_extra [SLOTS];
  bit          r_valid [SLOTS];
  bit          sticky_err;
  int          active_rules;

  result_t     pending_results[$];
  int          errors;
  bit          calm;
  int          n_req, n_res, n_red, n_acc, n_rej, n_ovf, n_lim;

  // First enabled rule whose right side matches the stack top
  function automatic int match_rule();
    int lim, len, base;
    bit ok;
    logic [7:0] b;
    lim = (active_rules < SLOTS) ? active_rules : SLOTS;
    for (int i = 0; i < lim; i++) begin
      if (!r_valid[i]) continue;
      len = r_len[i];
      if (len == 0 || len > MAX_LEN || len > stk_cnt) continue;
      base = stk_cnt - len;
      ok = 1'b1;
      for (int j = 0; j < len; j++) begin
        b = (j < 8) ? r_body[i][8*j +: 8] : r_extra[i];
        if (stk[base + j] != b) ok = 1'b0;
      end
      if (ok) return i;
    end
    return -1;
  endfunction

  function automatic result_t mk_res(act_t a, int rule, logic [7:0] sym, int lvl);
    result_t r;
    r.action = a;
    r.rule_used = rule[2:0];
    r.pushed_symbol = sym;
    r.stack_level = lvl[4:0];
    r.last = 1'b0;
    return r;
  endfunction

  // Record a rule load, or reduce greedily, then shift or close the expression
  task automatic parse_step(input request_t rq, output result_t last_res);
    result_t out[$];
    int r, done;
    last_res = mk_res(ACT_SHIFTED, 0, 8'd0, 0);
    if (rq.kind == REQ_LOAD) begin
      r_left[rq.slot] = rq.left;
      r_len[rq.slot] = rq.length;
      r_body[rq.slot] = rq.head;
      r_extra[rq.slot] = rq.tail;
      r_valid[rq.slot] = (rq.length >= 1 && rq.length <= MAX_LEN);
      return;
    end
    if (rq.kind == REQ_NONE) return;
    done = 0;
    forever begin
      r = match_rule();
      if (r < 0) break;
      if (done >= MAX_RED) begin
        sticky_err = 1'b1;
        out.push_back(mk_res(ACT_LIMIT, 0, 8'd0, stk_cnt));
        break;
      end
      stk_cnt = stk_cnt - r_len[r] + 1;
      stk[stk_cnt - 1] = r_left[r];
      out.push_back(mk_res(ACT_REDUCED, r, r_left[r], stk_cnt));
      done++;
    end
    if (rq.kind == REQ_SHIFT) begin
      if (stk_cnt >= DEPTH) begin
        sticky_err = 1'b1;
        out.push_back(mk_res(ACT_OVERFLOW, 0, rq.symbol, stk_cnt));
      end else begin
        stk[stk_cnt] = rq.symbol;
        stk_cnt++;
        out.push_back(mk_res(ACT_SHIFTED, 0, rq.symbol, stk_cnt));
      end
    end else begin
      out.push_back(mk_res((stk_cnt == 1 && !sticky_err) ? ACT_ACCEPTED : ACT_REJECTED,
                           0, 8'd0, stk_cnt));
      stk_cnt = 0;
      sticky_err = 1'b0;
    end
    out[out.size() - 1].last = 1'b1;
    last_res = out[out.size() - 1];
    foreach (out[k]) pending_results.push_back(out[k]);
  endtask

  // Drive one request; lower valid only when a gap comes before it
  task automatic send_request(input request_t rq, output result_t last_res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rq.kind;
    req_ch.symbol <= rq.symbol;
    req_ch.rule_slot <= rq.slot;
    req_ch.rule_left <= rq.left;
    req_ch.rule_length <= rq.length;
    req_ch.rule_body_head <= rq.head;
    req_ch.rule_body_tail <= rq.tail;
    do @(posedge clk); while (!req_ch.ready);
    n_req++;
    parse_step(rq, last_res);
  endtask

  // Hold off until every expected result is back, then let loads settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rules_in_use(input logic [3:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    active_rules = v;
  endtask

  function automatic request_t noise();
    request_t rq;
    rq.kind = req_t'($urandom_range(0, 3));
    rq.symbol = $urandom_range(0, 255);
    rq.slot = $urandom_range(0, 7);
    rq.left = $urandom_range(0, 255);
    rq.length = $urandom_range(0, 15);
    rq.head = {$urandom, $urandom};
    rq.tail = $urandom_range(0, 255);
    return rq;
  endfunction

  function automatic logic [7:0] letter();
    return 8'h40 + $urandom_range(0, 3);
  endfunction

  // Mostly small-alphabet grammars and sentences, some wild requests
  function automatic request_t random_request();
    request_t rq;
    int pick;
    rq = noise();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      rq.kind = REQ_LOAD;
      rq.left = letter();
      rq.length = $urandom_range(1, 3);
      for (int j = 0; j < 8; j++) rq.head[8*j +: 8] = letter();
    end else if (pick < 18) begin
      rq.kind = REQ_LOAD;
    end else if (pick < 20) begin
      rq.kind = REQ_NONE;
    end else if (pick < 32) begin
      rq.kind = REQ_END;
    end else begin
      rq.kind = REQ_SHIFT;
      if ($urandom_range(0, 99) < 85) rq.symbol = letter();
    end
    return rq;
  endfunction

  function automatic table_row_t row(req_t k, logic [7:0] sym, logic [2:0] slot,
                                     logic [7:0] left, logic [3:0] len,
                                     logic [63:0] head, logic [7:0] tail, int reps,
                                     bit typed, act_t a, int lvl);
    table_row_t t;
    t.rq = '{k, sym, slot, left, len, head, tail};
    t.reps = reps;
    t.typed = typed;
    t.t_act = a;
    t.t_level = lvl;
    return t;
  endfunction

  // Result receiver with random stalls
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (res_ch.valid && res_ch.ready) begin
      stall_left = calm ? 0 : $urandom_range(0, 17);
      res_ch.ready <= (stall_left == 0);
    end else begin
      if (stall_left > 0) stall_left = stall_left - 1;
      res_ch.ready <= (stall_left == 0);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result action=%0d sym=%0h level=%0d", $time,
                 res_ch.action, res_ch.pushed_symbol, res_ch.stack_level);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_res++;
        case (act_t'(e.action))
          ACT_REDUCED:  n_red++;
          ACT_ACCEPTED: n_acc++;
          ACT_REJECTED: n_rej++;
          ACT_OVERFLOW: n_ovf++;
          ACT_LIMIT:    n_lim++;
          default: ;
        endcase
        if (res_ch.action !== e.action || res_ch.rule_used !== e.rule_used ||
            res_ch.pushed_symbol !== e.pushed_symbol ||
            res_ch.stack_level !== e.stack_level || res_ch.last !== e.last) begin
          $display("%0t: mismatch expected act=%0d rule=%0d sym=%0h lvl=%0d last=%0b",
                   $time, e.action, e.rule_used, e.pushed_symbol, e.stack_level, e.last);
          $display("%0t:          actual   act=%0d rule=%0d sym=%0h lvl=%0d last=%0b",
                   $time, res_ch.action, res_ch.rule_used, res_ch.pushed_symbol,
                   res_ch.stack_level, res_ch.last);
          errors++;
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    table_row_t tbl[$];
    result_t lr;
    int counts[5];
    logic [3:0] cfg_vals[5];
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_NONE;
    req_ch.symbol = '0;
    req_ch.rule_slot = '0;
    req_ch.rule_left = '0;
    req_ch.rule_length = '0;
    req_ch.rule_body_head = '0;
    req_ch.rule_body_tail = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    stk_cnt = 0;
    sticky_err = 1'b0;
    active_rules = 8;
    foreach (r_valid[i]) r_valid[i] = 1'b0;
    errors = 0;
    calm = 1'b0;
    {n_req, n_res, n_red, n_acc, n_rej, n_ovf, n_lim} = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty expression, grammar E -> a | E + E, a full-width rule, bad lengths
    tbl.push_back(row(REQ_END,   8'h00, 0, 8'h00, 1, 64'h0, 8'h00, 1, 1, ACT_REJECTED, 0));
    tbl.push_back(row(REQ_LOAD,  8'h00, 0, 8'h45, 1, 64'h61, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_LOAD,  8'h00, 1, 8'h45, 3, 64'h452B45, 8'h00, 1, 0,
                      ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_LOAD,  8'hFF, 7, 8'h00, 9, '1, 8'hFF, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_LOAD,  8'h00, 6, 8'hFF, 0, 64'h0, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_LOAD,  8'h00, 5, 8'h12, 15, '1, 8'hFF, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_SHIFT, 8'h61, 0, 8'h00, 0, 64'h0, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_SHIFT, 8'h2B, 0, 8'h00, 0, 64'h0, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_SHIFT, 8'h61, 0, 8'h00, 0, 64'h0, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_NONE,  8'h61, 3, 8'h61, 1, 64'h61, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_END,   8'h00, 0, 8'h00, 0, 64'h0, 8'h00, 1, 1, ACT_ACCEPTED, 1));
    tbl.push_back(row(REQ_SHIFT, 8'h00, 0, 8'h00, 0, 64'h0, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_END,   8'h00, 0, 8'h00, 0, 64'h0, 8'h00, 1, 1, ACT_ACCEPTED, 1));
    // Nine 0xFF reduce through the longest rule
    tbl.push_back(row(REQ_SHIFT, 8'hFF, 0, 8'h00, 0, 64'h0, 8'h00, 9, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_END,   8'h00, 0, 8'h00, 0, 64'h0, 8'h00, 1, 1, ACT_ACCEPTED, 1));
    // Unit-rule cycle hits the reduction limit and poisons the expression
    tbl.push_back(row(REQ_LOAD,  8'h00, 2, 8'h10, 1, 64'h11, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_LOAD,  8'h00, 3, 8'h11, 1, 64'h10, 8'h00, 1, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_SHIFT, 8'h10, 0, 8'h00, 0, 64'h0, 8'h00, 2, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_END,   8'h00, 0, 8'h00, 0, 64'h0, 8'h00, 1, 1, ACT_REJECTED, 2));
    // Fill the stack past its depth
    tbl.push_back(row(REQ_SHIFT, 8'h33, 0, 8'h00, 0, 64'h0, 8'h00, 17, 0, ACT_SHIFTED, 0));
    tbl.push_back(row(REQ_END,   8'h00, 0, 8'h00, 0, 64'h0, 8'h00, 1, 1, ACT_REJECTED, 16));

    // Walk the table
    foreach (tbl[i]) begin
      for (int k = 0; k < tbl[i].reps; k++) send_request(tbl[i].rq, lr);
      if (tbl[i].typed && (lr.action !== tbl[i].t_act || lr.stack_level != tbl[i].t_level)) begin
        $display("%0t: row %0d expected act=%0d lvl=%0d, predicted act=%0d lvl=%0d",
                 $time, i, tbl[i].t_act, tbl[i].t_level, lr.action, lr.stack_level);
        errors++;
      end
    end

    // Random phases across rule-count settings, one of them without idling
    cfg_vals = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd1};
    counts = '{30, 15, 30, 25, 24};
    for (int p = 0; p < 5; p++) begin
      write_rules_in_use(cfg_vals[p]);
      calm = (p == 3);
      for (int k = 0; k < counts[p]; k++) send_request(random_request(), lr);
    end
    calm = 1'b0;
    drain();
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) errors++;

    $display("%0d requests, %0d results: %0d reductions, %0d accepted, %0d rejected,",
             n_req, n_res, n_red, n_acc, n_rej);
    $display("%0d overflows, %0d reduction limits over five rule-count settings",
             n_ovf, n_lim);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
